// File: design/frame_deadline_calculator_defines.svh
// Assertion helpers used by the checker file fdc_checker.sv.
`ifndef FRAME_DEADLINE_CALCULATOR_DEFINES_SVH
`define FRAME_DEADLINE_CALCULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame deadline check failed");

// Consequent must hold in the cycle after the antecedent.
`define FDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame deadline check failed");

`endif

// File: design/fdc_pkg.sv
package fdc_pkg;

    localparam int DEF_RATE_BITS = 16;
    localparam int RATE_RESET    = 30;
    localparam int START_W       = 64;
    localparam int INDEX_W       = 64;
    localparam int DEADLINE_W    = 63;
    localparam int CFG_RATE_W    = 16;

    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_SEC = 20'd1000000;

    // Largest whole-second count whose microsecond value still fits in 63 bits
    localparam int SECS_W = 44;
    localparam logic [INDEX_W-1:0] MAX_SECS = 64'd9223372036854;

    // Quotient bits resolved per divider stage
    localparam int DIV_BPS = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RATE = 2'd1,
        ST_OVERFLOW = 2'd2
    } fdc_status_t;

    typedef enum logic {
        REG_START_TIME = 1'b0,
        REG_FRAME_RATE = 1'b1
    } fdc_reg_t;

    typedef struct packed {
        logic bad_rate;
        logic secs_ovf;
    } fdc_flags_t;

endpackage

// File: design/fdc_divider.sv
module fdc_divider #(
    parameter int QW  = 64,
    parameter int RB  = 16,
    parameter int SW  = 1,
    parameter int BPS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [RB-1:0] in_rem,
    input  logic [QW-1:0] in_num,
    input  logic [RB-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [RB-1:0] out_rem,
    output logic [RB-1:0] out_den,
    output logic [SW-1:0] out_side
);

    localparam int NSTG = QW / BPS;

    logic          vld_reg  [NSTG];
    logic [RB-1:0] rem_reg  [NSTG];
    logic [QW-1:0] num_reg  [NSTG];
    logic [RB-1:0] den_reg  [NSTG];
    logic [SW-1:0] side_reg [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic          vld_in;
        logic [RB-1:0] rem_in;
        logic [QW-1:0] num_in;
        logic [RB-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [RB-1:0] rem_next;
        logic [QW-1:0] num_next;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_rem;
            assign num_in  = in_num;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign num_in  = num_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // Restoring division: shift in one dividend bit, subtract when it fits,
        // and shift the quotient bit into the vacated low end.
        always_comb
        begin : step
            logic [RB:0]   t;
            logic [RB-1:0] r;
            logic [QW-1:0] n;
            logic          qb;
            r  = rem_in;
            n  = num_in;
            t  = '0;
            qb = 1'b0;
            for (int j = 0; j < BPS; j++)
            begin
                t  = {r, n[QW-1]};
                qb = (t >= {1'b0, den_in});
                if (qb)
                begin
                    r = RB'(t - {1'b0, den_in});
                end
                else
                begin
                    r = t[RB-1:0];
                end
                n = {n[QW-2:0], qb};
            end
            rem_next = r;
            num_next = n;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                num_reg[s]  <= num_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_quo   = num_reg[NSTG-1];
    assign out_rem   = rem_reg[NSTG-1];
    assign out_den   = den_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

// File: design/fdc_finish.sv
module fdc_finish (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [fdc_pkg::US_W-1:0]          frac,
    input  logic [fdc_pkg::SECS_W-1:0]        secs,
    input  fdc_pkg::fdc_flags_t               flags,
    input  logic [fdc_pkg::START_W-1:0]       start_time,
    output logic                              out_valid,
    output logic [fdc_pkg::DEADLINE_W-1:0]    deadline,
    output fdc_pkg::fdc_status_t              status
);

    localparam int OW = fdc_pkg::DEADLINE_W;
    localparam int SW = fdc_pkg::START_W;

    // Stage A: whole seconds to microseconds
    logic                       a_vld_reg;
    logic [OW-1:0]              a_mul_reg;
    logic [fdc_pkg::US_W-1:0]   a_frac_reg;
    fdc_pkg::fdc_flags_t        a_flags_reg;
    logic [OW-1:0]              a_mul_next;

    // Stage B: offset from start
    logic                       b_vld_reg;
    logic [SW-1:0]              b_off_reg;
    fdc_pkg::fdc_flags_t        b_flags_reg;
    logic [SW-1:0]              b_off_next;

    // Output stage
    logic                       o_vld_reg;
    logic [OW-1:0]              o_dl_reg;
    fdc_pkg::fdc_status_t       o_st_reg;
    logic [OW-1:0]              o_dl_next;
    fdc_pkg::fdc_status_t       o_st_next;
    logic [SW-1:0]              sum;

    assign a_mul_next = OW'(secs) * OW'(fdc_pkg::US_PER_SEC);
    // The offset can pass 2^63 - 1 by up to a second, so keep all 64 bits
    assign b_off_next = SW'(a_mul_reg) + SW'(a_frac_reg);

    // With start below 2^63 and offset bit 63 clear, bit 63 of the sum flags overflow
    assign sum = start_time + b_off_reg;

    always_comb
    begin
        o_dl_next = '0;
        o_st_next = fdc_pkg::ST_OK;
        if (b_flags_reg.bad_rate)
        begin
            o_st_next = fdc_pkg::ST_BAD_RATE;
        end
        else if (b_flags_reg.secs_ovf || start_time[SW-1] || b_off_reg[SW-1] || sum[SW-1])
        begin
            o_st_next = fdc_pkg::ST_OVERFLOW;
        end
        else
        begin
            o_dl_next = sum[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            o_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mul_reg   <= a_mul_next;
            a_frac_reg  <= frac;
            a_flags_reg <= flags;
            b_off_reg   <= b_off_next;
            b_flags_reg <= a_flags_reg;
            o_dl_reg    <= o_dl_next;
            o_st_reg    <= o_st_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign deadline  = o_dl_reg;
    assign status    = o_st_reg;

endmodule

// File: design/frame_deadline_calculator.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    frame_index
// out       out_valid / out_ready  deadline, status
// cfg       cfg_we                 cfg_index, cfg_data
//
// One item per cycle unless the output stalls; the two restoring dividers
// resolve four quotient bits per stage.
// Reset clears all valid bits and loads start_time 0, frame_rate 30.
// A stall at the output freezes the whole pipeline; in_ready drops with it.
module frame_deadline_calculator #(
    parameter int RATE_BITS = fdc_pkg::DEF_RATE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [fdc_pkg::START_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fdc_pkg::INDEX_W-1:0]         frame_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fdc_pkg::DEADLINE_W-1:0]      deadline,
    output logic [1:0]                          status
);

    localparam int RB    = RATE_BITS;
    localparam int QW    = fdc_pkg::INDEX_W;
    localparam int UW    = fdc_pkg::US_W;
    localparam int PW    = RB + UW;
    localparam int KEEP  = (RB < fdc_pkg::CFG_RATE_W) ? RB : fdc_pkg::CFG_RATE_W;
    localparam int SIDE2 = fdc_pkg::SECS_W + 2;

    logic [fdc_pkg::START_W-1:0] start_time_reg;
    logic [RB-1:0]               frame_rate_reg;
    logic                        adv;
    fdc_pkg::fdc_status_t        st_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            frame_rate_reg <= RB'(fdc_pkg::RATE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdc_pkg::REG_START_TIME: start_time_reg <= cfg_data;
                fdc_pkg::REG_FRAME_RATE: frame_rate_reg <= RB'(cfg_data[KEEP-1:0]);
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Whole seconds and leftover frames
    logic          d1_vld;
    logic [QW-1:0] d1_quo;
    logic [RB-1:0] d1_rem;
    logic [RB-1:0] d1_den;
    logic [0:0]    d1_side;

    fdc_divider #(.QW(QW), .RB(RB), .SW(1), .BPS(fdc_pkg::DIV_BPS)) u_div_secs (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_rem    ('0),
        .in_num    (frame_index),
        .in_den    (frame_rate_reg),
        .in_side   (frame_rate_reg == '0),
        .out_valid (d1_vld),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_den   (d1_den),
        .out_side  (d1_side)
    );

    // Scale leftover frames to microseconds, check the second count
    logic                         s1_vld_reg;
    logic [PW-1:0]                s1_prod_reg;
    logic [RB-1:0]                s1_den_reg;
    logic [fdc_pkg::SECS_W-1:0]   s1_secs_reg;
    fdc_pkg::fdc_flags_t          s1_flags_reg;
    fdc_pkg::fdc_flags_t          s1_flags_next;

    always_comb
    begin
        s1_flags_next.bad_rate = d1_side[0];
        s1_flags_next.secs_ovf = (d1_quo > fdc_pkg::MAX_SECS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg  <= PW'(d1_rem) * PW'(fdc_pkg::US_PER_SEC);
            s1_den_reg   <= d1_den;
            s1_secs_reg  <= d1_quo[fdc_pkg::SECS_W-1:0];
            s1_flags_reg <= s1_flags_next;
        end
    end

    // Fraction of a second; the product is below rate * 2^20, so its
    // upper bits already form a valid partial remainder
    logic             d2_vld;
    logic [UW-1:0]    d2_quo;
    logic [RB-1:0]    d2_rem;
    logic [RB-1:0]    d2_den;
    logic [SIDE2-1:0] d2_side;

    fdc_divider #(.QW(UW), .RB(RB), .SW(SIDE2), .BPS(fdc_pkg::DIV_BPS)) u_div_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_vld_reg),
        .in_rem    (s1_prod_reg[PW-1:UW]),
        .in_num    (s1_prod_reg[UW-1:0]),
        .in_den    (s1_den_reg),
        .in_side   ({s1_flags_reg, s1_secs_reg}),
        .out_valid (d2_vld),
        .out_quo   (d2_quo),
        .out_rem   (d2_rem),
        .out_den   (d2_den),
        .out_side  (d2_side)
    );

    fdc_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (d2_vld && (d2_rem < d2_den || d2_den == '0 || 1'b1)),
        .frac        (d2_quo),
        .secs        (d2_side[fdc_pkg::SECS_W-1:0]),
        .flags       (d2_side[SIDE2-1:fdc_pkg::SECS_W]),
        .start_time  (start_time_reg),
        .out_valid   (out_valid),
        .deadline    (deadline),
        .status      (st_out)
    );

    assign status = st_out;

endmodule

// File: design/fdc_checker.sv
`include "frame_deadline_calculator_defines.svh"

module fdc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [fdc_pkg::DEADLINE_W-1:0]    deadline,
    input logic [1:0]                        status
);

    `FDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `FDC_ASSERT_NEXT(a_data_hold, out_valid && !out_ready, $stable(deadline) && $stable(status))
    `FDC_ASSERT_SAME(a_err_zero, out_valid && status != fdc_pkg::ST_OK, deadline == '0)
    `FDC_ASSERT_SAME(a_status_code, out_valid, status <= fdc_pkg::ST_OVERFLOW)
    `FDC_ASSERT_SAME(a_ready_flow, 1'b1, in_ready == (!out_valid || out_ready))

endmodule

bind frame_deadline_calculator fdc_checker u_fdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .deadline    (deadline),
    .status      (status)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 25;
    localparam int N_RANDOM = 1500;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam logic [63:0] TS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SECS_LIMIT = 64'd9223372036854;

    typedef struct packed {
        logic [fdc_pkg::DEADLINE_W-1:0] deadline;
        fdc_pkg::fdc_status_t           stat;
    } deadline_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [fdc_pkg::START_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [fdc_pkg::INDEX_W-1:0] frame_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [fdc_pkg::DEADLINE_W-1:0] deadline;
    logic [1:0] status;

    logic [63:0] model_start = 64'd0;
    logic [15:0] model_rate = 16'd30;

    logic [63:0] pending_frames[$];
    deadline_t   expected_deadlines[$];
    int          mismatch_count = 0;
    longint unsigned cycle_count = 0;
    bit          hold_off = 1'b0;
    int          send_wait = 0;
    int          recv_wait = 0;

    frame_deadline_calculator i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .frame_index(frame_index), .out_valid(out_valid), .out_ready(out_ready),
        .deadline(deadline), .status(status)
    );

    always #1 clk = ~clk;

    function automatic deadline_t compute_deadline(logic [63:0] seq);
        deadline_t r;
        logic [63:0] secs;
        logic [63:0] rem;
        logic [63:0] offset;
        r.deadline = '0;
        r.stat = fdc_pkg::ST_OK;
        if (model_rate == 16'd0) begin
            r.stat = fdc_pkg::ST_BAD_RATE;
        end
        else begin
            secs = seq / {48'd0, model_rate};
            rem = seq % {48'd0, model_rate};
            if (secs > SECS_LIMIT) begin
                r.stat = fdc_pkg::ST_OVERFLOW;
            end
            else begin
                offset = secs * 64'd1000000 + (rem * 64'd1000000) / {48'd0, model_rate};
                if (model_start[63]) begin
                    r.stat = fdc_pkg::ST_OVERFLOW;
                end
                else if (offset > TS_MAX - model_start) begin
                    r.stat = fdc_pkg::ST_OVERFLOW;
                end
                else begin
                    r.deadline = fdc_pkg::DEADLINE_W'(model_start + offset);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    // Driver: one item from the queue, with a random gap before each.
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            expected_deadlines.push_back(compute_deadline(frame_index));
        end
        if (!in_valid || in_ready) begin
            if (send_wait > 0) begin
                in_valid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (rst_n && pending_frames.size() > 0) begin
                in_valid <= 1'b1;
                frame_index <= pending_frames.pop_front();
                send_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each item, then stall for a random count.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (out_valid && out_ready) begin
            if (expected_deadlines.size() == 0) begin
                report_mismatch("unexpected item", deadline, 0);
            end
            else begin
                deadline_t want;
                want = expected_deadlines.pop_front();
                if (deadline !== want.deadline)
                    report_mismatch("deadline", deadline, want.deadline);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
            recv_wait = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
        end
        else if (recv_wait > 0) begin
            recv_wait = recv_wait - 1;
        end
        out_ready <= rst_n && !hold_off && recv_wait == 0;
    end

    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL frame_deadline_calculator");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_frames.size() > 0 || in_valid || expected_deadlines.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(fdc_pkg::fdc_reg_t idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fdc_pkg::REG_START_TIME) model_start = value;
        else model_rate = value[15:0];
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_frame();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = v & 64'hFFFF;
            2: v = {48'd0, model_rate} * $urandom_range(0, 100) + $urandom_range(0, 3);
            3: v = 64'd9223372036854 * model_rate + $urandom_range(0, 200) - 100;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [63:0] starts[6];
        logic [15:0] rates[6];
        starts = '{64'd0, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'd1_700_000_000_000_000};
        rates = '{16'd30, 16'd0, 16'd1, 16'hFFFF, 16'd25, 16'd60};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes, second and sum boundaries, zero rate.
        pending_frames = '{64'd0, 64'd1, 64'd29, 64'd30, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'h8000_0000_0000_0000, 64'd9223372036854 * 30,
                           64'd9223372036855 * 30, 64'd9223372036854 * 30 + 29};
        wait_drained();
        write_reg(fdc_pkg::REG_FRAME_RATE, 64'd1);
        write_reg(fdc_pkg::REG_START_TIME, 64'd807);
        pending_frames = '{64'd9223372036854, 64'd9223372036855, 64'd9223372036853};
        wait_drained();
        write_reg(fdc_pkg::REG_START_TIME, 64'd808);
        pending_frames = '{64'd9223372036854, 64'd0};
        wait_drained();
        write_reg(fdc_pkg::REG_FRAME_RATE, 64'd0);
        pending_frames = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
        wait_drained();
        write_reg(fdc_pkg::REG_FRAME_RATE, 64'hFFFF);
        write_reg(fdc_pkg::REG_START_TIME, 64'h8000_0000_0000_0000);
        pending_frames = '{64'd0, 64'd65535, 64'hFFFF_FFFF_FFFF_FFFF};
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            if (phase < 6) write_reg(fdc_pkg::REG_START_TIME, starts[phase]);
            else write_reg(fdc_pkg::REG_START_TIME,
                           {1'b0, $urandom_range(0, 1) ? 31'd0 : 31'($urandom), $urandom});
            write_reg(fdc_pkg::REG_FRAME_RATE, phase < 6 ? {48'd0, rates[phase]}
                                                         : 64'($urandom_range(0, 65535)));
            for (int n = 0; n < N_RANDOM / 12; n++)
                pending_frames.push_back(random_frame());
            if (phase == 3) begin
                // Stall the output long enough to back the pipeline up.
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("PASS frame_deadline_calculator");
        end
        else begin
            $display("FAIL frame_deadline_calculator");
        end
        $finish;
    end
endmodule
